/* design/bti_pkg.sv */
// ----------------------------------------------------------------------------
// bti_pkg
// Shared types and codes of the bilinear table interpolator.
// ----------------------------------------------------------------------------
package bti_pkg;

   localparam int AXIS_BITS = 16;
   localparam int CNT_BITS  = 8;

   typedef enum logic [1:0] {
      OP_LOOKUP  = 2'd0,
      OP_WRITE_X = 2'd1,
      OP_WRITE_Y = 2'd2,
      OP_WRITE_G = 2'd3
   } op_type;

   localparam logic [1:0] CASE_INSIDE    = 2'd0;
   localparam logic [1:0] CASE_CORNER    = 2'd1;
   localparam logic [1:0] CASE_X_CLAMPED = 2'd2;
   localparam logic [1:0] CASE_Y_CLAMPED = 2'd3;

   localparam logic CSR_X_COUNT = 1'b0;
   localparam logic CSR_Y_COUNT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_WEIGHT,
      ST_MAC,
      ST_DIV_INIT,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                wr_x;
      logic                wr_y;
      logic                wr_grid;
      logic                load_query;
      logic                search_issue;
      logic                weight_load;
      logic                mac_start;
      logic                mac_issue;
      logic                div_load;
      logic                div_step;
      logic                out_load;
      logic [CNT_BITS-1:0] cnt;
   } cmd_type;

   typedef struct packed {
      logic search_done;
      logic out_free;
   } status_type;

endpackage

/* design/bti_axis.sv */
// ----------------------------------------------------------------------------
// bti_axis
// One axis: point memory, serial neighbor search and interpolation weights.
// ----------------------------------------------------------------------------
module bti_axis #(
   parameter int MAX_POINTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [$clog2(MAX_POINTS)-1:0]       wr_idx,
   input  logic signed [bti_pkg::AXIS_BITS-1:0] wr_data,
   input  logic [4:0]                          count,
   input  logic signed [bti_pkg::AXIS_BITS-1:0] query,
   input  logic                                clear,
   input  logic                                issue,
   input  logic [bti_pkg::CNT_BITS-1:0]        rd_cnt,
   input  logic                                weight_load,
   output logic                                done,
   output logic                                pair,
   output logic [$clog2(MAX_POINTS)-1:0]       lo,
   output logic [bti_pkg::AXIS_BITS-1:0]       w0,
   output logic [bti_pkg::AXIS_BITS-1:0]       w1,
   output logic [bti_pkg::AXIS_BITS-1:0]       den
);
   import bti_pkg::*;

   localparam int IB = $clog2(MAX_POINTS);

   logic signed [AXIS_BITS-1:0] mem [MAX_POINTS];
   logic signed [AXIS_BITS-1:0] rd_ff;
   logic [CNT_BITS-1:0]         d_ff;
   logic                        sv_ff;
   logic                        done_ff, done_in;
   logic                        pair_ff, pair_in;
   logic [IB-1:0]               lo_ff, lo_in;
   logic signed [AXIS_BITS-1:0] prev_ff, p1_ff, p1_in, p2_ff, p2_in;
   logic [AXIS_BITS-1:0]        w0_ff, w1_ff, den_ff;
   logic [CNT_BITS-1:0]         n;
   logic                        hit, clamp_first, clamp_last, eval;
   logic signed [AXIS_BITS:0]   d_hi, d_lo, d_span;

   // Count zero acts as one, counts above the depth act as the depth.
   always_comb begin
      if (count == 5'd0) n = CNT_BITS'(1);
      else if (CNT_BITS'(count) > CNT_BITS'(MAX_POINTS)) n = CNT_BITS'(MAX_POINTS);
      else n = CNT_BITS'(count);
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_data;
      rd_ff <= mem[rd_cnt[IB-1:0]];
      d_ff  <= rd_cnt;
   end

   always_comb begin
      eval        = sv_ff && !done_ff;
      hit         = 1'b0;
      clamp_first = 1'b0;
      if (d_ff == '0) clamp_first = !(query > rd_ff);
      else hit = query < rd_ff;
      clamp_last  = !hit && !clamp_first && (d_ff == n - CNT_BITS'(1));
      done_in     = done_ff;
      pair_in     = pair_ff;
      lo_in       = lo_ff;
      p1_in       = p1_ff;
      p2_in       = p2_ff;
      if (eval) begin
         if (clamp_first) begin
            done_in = 1'b1;
            pair_in = 1'b0;
            lo_in   = '0;
         end else if (hit) begin
            done_in = 1'b1;
            pair_in = 1'b1;
            lo_in   = IB'(d_ff - CNT_BITS'(1));
            p1_in   = prev_ff;
            p2_in   = rd_ff;
         end else if (clamp_last) begin
            done_in = 1'b1;
            pair_in = 1'b0;
            lo_in   = IB'(d_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         sv_ff   <= issue;
         done_ff <= clear ? 1'b0 : done_in;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
      lo_ff   <= lo_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      if (eval) prev_ff <= rd_ff;
   end

   assign d_hi   = {p2_ff[AXIS_BITS-1], p2_ff} - {query[AXIS_BITS-1], query};
   assign d_lo   = {query[AXIS_BITS-1], query} - {p1_ff[AXIS_BITS-1], p1_ff};
   assign d_span = {p2_ff[AXIS_BITS-1], p2_ff} - {p1_ff[AXIS_BITS-1], p1_ff};

   // A clamped axis weighs only its low point, over a divisor of one.
   always_ff @(posedge clock) begin
      if (weight_load) begin
         if (pair_ff) begin
            w0_ff  <= d_hi[AXIS_BITS-1:0];
            w1_ff  <= d_lo[AXIS_BITS-1:0];
            den_ff <= d_span[AXIS_BITS-1:0];
         end else begin
            w0_ff  <= AXIS_BITS'(1);
            w1_ff  <= '0;
            den_ff <= AXIS_BITS'(1);
         end
      end
   end

   assign done = done_ff;
   assign pair = pair_ff;
   assign lo   = lo_ff;
   assign w0   = w0_ff;
   assign w1   = w1_ff;
   assign den  = den_ff;

endmodule

/* design/bti_datapath.sv */
// ----------------------------------------------------------------------------
// bti_datapath
// Axis units, grid memory, multiply-accumulate, serial divider and output.
// ----------------------------------------------------------------------------
module bti_datapath #(
   parameter int MAX_X_POINTS = 16,
   parameter int MAX_Y_POINTS = 16,
   parameter int VALUE_BITS   = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bti_pkg::cmd_type                      cmd,
   output bti_pkg::status_type                   status,
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [4:0]                            csr_wdata,
   input  logic [7:0]                            entry_index,
   input  logic signed [VALUE_BITS-1:0]          grid_data,
   input  logic signed [bti_pkg::AXIS_BITS-1:0]  axis_data,
   input  logic signed [bti_pkg::AXIS_BITS-1:0]  x_query,
   input  logic signed [bti_pkg::AXIS_BITS-1:0]  y_query,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic signed [VALUE_BITS-1:0]          interp_value,
   output logic [1:0]                            case_code
);
   import bti_pkg::*;

   localparam int XB = $clog2(MAX_X_POINTS);
   localparam int YB = $clog2(MAX_Y_POINTS);
   localparam int AW = VALUE_BITS + 34;
   localparam int PW = VALUE_BITS + 33;

   logic [4:0]                  x_count_ff, y_count_ff;
   logic signed [AXIS_BITS-1:0] xq_ff, yq_ff;
   logic                        x_done, y_done, x_pair, y_pair;
   logic [XB-1:0]               x_lo;
   logic [YB-1:0]               y_lo;
   logic [AXIS_BITS-1:0]        xw0, xw1, xden, yw0, yw1, yden;
   logic                        x_wr_ok, y_wr_ok, g_wr_ok;

   logic signed [VALUE_BITS-1:0] grid_mem [2**(XB+YB)];
   logic signed [VALUE_BITS-1:0] g_rd_ff;
   logic [XB+YB-1:0]             g_waddr, g_raddr;
   logic [XB-1:0]                t_row;
   logic [YB-1:0]                t_col;
   logic [AXIS_BITS-1:0]         t_wx, t_wy;
   logic [31:0]                  w_ff, den_ff;
   logic signed [PW-1:0]         prod_ff;
   logic signed [AW-1:0]         acc_ff;
   logic                         v1_ff, v2_ff;

   logic [AW-1:0]               quo_ff, mag;
   logic [32:0]                 rem_ff, trial;
   logic                        neg_ff;
   logic [VALUE_BITS-1:0]       q_mag;
   logic                        rsp_valid_ff;
   logic signed [VALUE_BITS-1:0] value_ff;
   logic [1:0]                  code_ff, code_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_count_ff <= 5'd1;
         y_count_ff <= 5'd1;
      end else if (csr_we) begin
         if (csr_index == CSR_X_COUNT) x_count_ff <= csr_wdata;
         else y_count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         xq_ff <= x_query;
         yq_ff <= y_query;
      end
   end

   assign x_wr_ok = cmd.wr_x && (entry_index < 8'(MAX_X_POINTS));
   assign y_wr_ok = cmd.wr_y && (entry_index < 8'(MAX_Y_POINTS));
   assign g_wr_ok = cmd.wr_grid && (8'(entry_index[7:4]) < 8'(MAX_X_POINTS))
                    && (8'(entry_index[3:0]) < 8'(MAX_Y_POINTS));

   bti_axis #(.MAX_POINTS(MAX_X_POINTS)) u_x_axis (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (x_wr_ok),
      .wr_idx      (entry_index[XB-1:0]),
      .wr_data     (axis_data),
      .count       (x_count_ff),
      .query       (xq_ff),
      .clear       (cmd.load_query),
      .issue       (cmd.search_issue),
      .rd_cnt      (cmd.cnt),
      .weight_load (cmd.weight_load),
      .done        (x_done),
      .pair        (x_pair),
      .lo          (x_lo),
      .w0          (xw0),
      .w1          (xw1),
      .den         (xden)
   );

   bti_axis #(.MAX_POINTS(MAX_Y_POINTS)) u_y_axis (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (y_wr_ok),
      .wr_idx      (entry_index[YB-1:0]),
      .wr_data     (axis_data),
      .count       (y_count_ff),
      .query       (yq_ff),
      .clear       (cmd.load_query),
      .issue       (cmd.search_issue),
      .rd_cnt      (cmd.cnt),
      .weight_load (cmd.weight_load),
      .done        (y_done),
      .pair        (y_pair),
      .lo          (y_lo),
      .w0          (yw0),
      .w1          (yw1),
      .den         (yden)
   );

   // Term k takes row x_lo + k[1] and column y_lo + k[0]. A clamped axis
   // gives its upper neighbor a weight of zero, so that read is don't-care.
   assign t_row   = x_lo + XB'(cmd.cnt[1]);
   assign t_col   = y_lo + YB'(cmd.cnt[0]);
   assign t_wx    = cmd.cnt[1] ? xw1 : xw0;
   assign t_wy    = cmd.cnt[0] ? yw1 : yw0;
   assign g_raddr = {t_row, t_col};
   assign g_waddr = {XB'(entry_index[7:4]), YB'(entry_index[3:0])};

   always_ff @(posedge clock) begin
      if (g_wr_ok) grid_mem[g_waddr] <= grid_data;
      g_rd_ff <= grid_mem[g_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= t_wx * t_wy;
      prod_ff <= $signed({1'b0, w_ff}) * g_rd_ff;
      if (cmd.mac_start) begin
         den_ff <= xden * yden;
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + AW'(prod_ff);
      end
   end

   // Restoring divide on magnitudes, one quotient bit per cycle.
   assign mag   = acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
   assign trial = {rem_ff[31:0], quo_ff[AW-1]};
   assign q_mag = quo_ff[VALUE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         quo_ff <= mag;
         rem_ff <= '0;
         neg_ff <= acc_ff[AW-1];
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= trial - {1'b0, den_ff};
            quo_ff <= {quo_ff[AW-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[AW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (x_pair && y_pair) code_c = CASE_INSIDE;
      else if (!x_pair && !y_pair) code_c = CASE_CORNER;
      else if (!x_pair) code_c = CASE_X_CLAMPED;
      else code_c = CASE_Y_CLAMPED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         value_ff <= neg_ff ? $signed(-q_mag) : $signed(q_mag);
         code_ff  <= code_c;
      end
   end

   assign status.search_done = x_done && y_done;
   assign status.out_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid         = rsp_valid_ff;
   assign interp_value       = value_ff;
   assign case_code          = code_ff;

endmodule

/* design/bti_ctrl.sv */
// ----------------------------------------------------------------------------
// bti_ctrl
// Sequencer: search, weights, multiply-accumulate, divide and hand-off.
// ----------------------------------------------------------------------------
module bti_ctrl #(
   parameter int VALUE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic [1:0]           req_op,
   output logic                 req_tready,
   input  bti_pkg::status_type  status,
   output bti_pkg::cmd_type     cmd
);
   import bti_pkg::*;

   localparam int AW = VALUE_BITS + 34;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept && (req_op == OP_LOOKUP)) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (status.search_done) begin
               state_in = ST_WEIGHT;
               cnt_in   = '0;
            end
         end
         ST_WEIGHT: begin
            state_in = ST_MAC;
         end
         ST_MAC: begin
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(5)) begin
               state_in = ST_DIV_INIT;
               cnt_in   = '0;
            end
         end
         ST_DIV_INIT: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(AW - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd     = '0;
      cmd.cnt = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.wr_x       = accept && (req_op == OP_WRITE_X);
            cmd.wr_y       = accept && (req_op == OP_WRITE_Y);
            cmd.wr_grid    = accept && (req_op == OP_WRITE_G);
            cmd.load_query = accept && (req_op == OP_LOOKUP);
         end
         ST_SEARCH: begin
            cmd.search_issue = !status.search_done;
         end
         ST_WEIGHT: begin
            cmd.weight_load = 1'b1;
         end
         ST_MAC: begin
            cmd.mac_start = (cnt_ff == '0);
            cmd.mac_issue = (cnt_ff < CNT_BITS'(4));
         end
         ST_DIV_INIT: begin
            cmd.div_load = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_DONE: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd.cnt = cnt_ff;
         end
      endcase
   end

endmodule

/* design/bilinear_table_interpolator.sv */
// ----------------------------------------------------------------------------
// bilinear_table_interpolator
// Clamped bilinear lookup over two loaded axes and a loaded value grid.
// ----------------------------------------------------------------------------
//  Group  Dir  Contents
//  req_   in   tuser: operation; tdata: entry_index, write_data, x_query,
//              y_query
//  rsp_   out  tuser: case_code; tdata: interp_value
//  csr_   in   we, index (0 x_count, 1 y_count), wdata
//
//  A write beat is absorbed in its accept cycle and the block stays ready.
//  A lookup runs the two axis searches in parallel, then the weights, the
//  multiply-accumulate and the one-bit-per-cycle divider.
//  A finished result waits in the output register while the next beat is
//  taken. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator #(
   parameter int MAX_X_POINTS = 16,
   parameter int MAX_Y_POINTS = 16,
   parameter int VALUE_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // entry_index[7:0], write_data[23:8], x_query[39:24], y_query[55:40]
   input  logic [55:0]                     req_tdata,
   // operation[1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // interp_value[VALUE_BITS-1:0], zero padded
   output logic [((VALUE_BITS+7)/8)*8-1:0] rsp_tdata,
   // case_code[1:0]
   output logic [1:0]                      rsp_tuser,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [4:0]                      csr_wdata
);
   import bti_pkg::*;

   localparam int RDW = ((VALUE_BITS + 7) / 8) * 8;

   cmd_type                      cmd;
   status_type                   status;
   logic signed [VALUE_BITS-1:0] value;

   bti_ctrl #(.VALUE_BITS(VALUE_BITS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bti_datapath #(
      .MAX_X_POINTS (MAX_X_POINTS),
      .MAX_Y_POINTS (MAX_Y_POINTS),
      .VALUE_BITS   (VALUE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .entry_index  (req_tdata[7:0]),
      .grid_data    (VALUE_BITS'(signed'(req_tdata[23:8]))),
      .axis_data    (req_tdata[23:8]),
      .x_query      (req_tdata[39:24]),
      .y_query      (req_tdata[55:40]),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .interp_value (value),
      .case_code    (rsp_tuser)
   );

   assign rsp_tdata = RDW'(unsigned'(value));

endmodule

/* design/bti_checker.sv */
// ----------------------------------------------------------------------------
// bti_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module bti_checker #(
   parameter int VALUE_BITS = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [1:0]                      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [((VALUE_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic [1:0]                      rsp_tuser
);
   import bti_pkg::*;

   logic lookup_beat, write_beat;

   assign lookup_beat = req_tvalid && req_tready && (req_tuser == OP_LOOKUP);
   assign write_beat  = req_tvalid && req_tready && (req_tuser != OP_LOOKUP);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      lookup_beat |=> !req_tready)
      else $error("ready right after a lookup beat");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      write_beat && !rsp_tvalid |=> !rsp_tvalid)
      else $error("write beat produced a result");

endmodule

bind bilinear_table_interpolator bti_checker #(.VALUE_BITS(VALUE_BITS)) u_bti_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
